>>> hw/rtl/snea_pkg.sv
package snea_pkg;

	localparam logic [1:0] KIND_TERM   = 2'd0;
	localparam logic [1:0] KIND_READ_N = 2'd1;
	localparam logic [1:0] KIND_READ_B = 2'd2;
	localparam logic [1:0] KIND_CLEAR  = 2'd3;

	localparam logic REG_MERGE_DUPLICATES = 1'b0;

	typedef enum logic [1:0] {
		OP_TERM,
		OP_READ_N,
		OP_READ_B,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [5:0]         column;
		logic [5:0]         read_column;
		logic               column_ok;
		logic               read_column_ok;
		logic signed [31:0] coefficient;
		logic signed [31:0] obs_value;
		logic [31:0]        obs_weight;
		logic               last_term;
	} cmd_t;

	typedef struct packed {
		logic pop;
		logic init;
	} status_t;

endpackage

>>> hw/rtl/snea_ram.sv
module snea_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> hw/rtl/snea_front.sv
module snea_front #(
	parameter int NUM_UNKNOWNS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic [1:0]            kind,
	input  logic [5:0]            column,
	input  logic [5:0]            read_column,
	input  logic signed [31:0]    coefficient,
	input  logic signed [31:0]    obs_value,
	input  logic [31:0]           obs_weight,
	input  logic                  last_term,
	input  snea_pkg::status_t     back_status,
	output logic                  q_valid,
	output snea_pkg::cmd_t        q_cmd
);

	snea_pkg::cmd_t fifo_q [2];
	snea_pkg::cmd_t cmd_in;
	logic           wp_q;
	logic           rp_q;
	logic [1:0]     cnt_q;
	logic           push;

	always_comb begin
		cmd_in.op = snea_pkg::OP_TERM;
		unique case (kind)
			snea_pkg::KIND_TERM:   cmd_in.op = snea_pkg::OP_TERM;
			snea_pkg::KIND_READ_N: cmd_in.op = snea_pkg::OP_READ_N;
			snea_pkg::KIND_READ_B: cmd_in.op = snea_pkg::OP_READ_B;
			snea_pkg::KIND_CLEAR:  cmd_in.op = snea_pkg::OP_CLEAR;
		endcase
		cmd_in.column         = column;
		cmd_in.read_column    = read_column;
		cmd_in.column_ok      = 32'(column) < NUM_UNKNOWNS;
		cmd_in.read_column_ok = 32'(read_column) < NUM_UNKNOWNS;
		cmd_in.coefficient    = coefficient;
		cmd_in.obs_value      = obs_value;
		cmd_in.obs_weight     = obs_weight;
		cmd_in.last_term      = last_term;
	end

	assign item_stall = (cnt_q == 2'd2) | back_status.init;
	assign push       = item_valid & ~item_stall;
	assign q_valid    = cnt_q != 2'd0;
	assign q_cmd      = fifo_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (back_status.pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(back_status.pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= cmd_in;
		end
	end

endmodule

>>> hw/rtl/snea_back.sv
module snea_back #(
	parameter int NUM_UNKNOWNS = 64,
	parameter int MAX_TERMS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               merge_duplicates,
	input  logic               q_valid,
	input  snea_pkg::cmd_t     q_cmd,
	output snea_pkg::status_t  status,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [63:0] read_data,
	output logic [62:0]        residual_sum,
	output logic [31:0]        observation_count,
	output logic               row_overflow,
	output logic               saturated
);

	localparam int MAT_SIZE = NUM_UNKNOWNS * (NUM_UNKNOWNS + 1) / 2;
	localparam int MA_W = $clog2(MAT_SIZE);
	localparam int RHS_AW = $clog2(NUM_UNKNOWNS);
	localparam int TA_W = $clog2(MAX_TERMS);
	localparam int TC_W = $clog2(MAX_TERMS + 1);
	localparam int TERM_W = 38;
	localparam logic [63:0] S64_MAX = 64'h7fff_ffff_ffff_ffff;
	localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

	typedef enum logic [20:0] {
		ST_SWEEP     = 21'd1,
		ST_IDLE      = 21'd2,
		ST_SRCH_RD   = 21'd4,
		ST_SRCH_CMP  = 21'd8,
		ST_APPEND    = 21'd16,
		ST_RD_ADDR   = 21'd32,
		ST_RD_DATA   = 21'd64,
		ST_ROW_START = 21'd128,
		ST_ROW_RD_I  = 21'd256,
		ST_ROW_GET_I = 21'd512,
		ST_ROW_RD_J  = 21'd1024,
		ST_ROW_GET_J = 21'd2048,
		ST_MUL_P     = 21'd4096,
		ST_ABS       = 21'd8192,
		ST_MUL_L     = 21'd16384,
		ST_MUL_H     = 21'd32768,
		ST_SCALE     = 21'd65536,
		ST_SCALE2    = 21'd131072,
		ST_ACC       = 21'd262144,
		ST_ACC2      = 21'd524288,
		ST_RESULT    = 21'd1048576
	} state_t;

	typedef enum logic [1:0] {
		TGT_RHS,
		TGT_NM,
		TGT_SQ
	} tgt_t;

	function automatic logic [12:0] tri_index(input logic [5:0] r, input logic [5:0] c);
		logic [5:0]  hi;
		logic [5:0]  lo;
		logic [12:0] prod;
		hi = (r < c) ? c : r;
		lo = (r < c) ? r : c;
		prod = {7'd0, hi} * ({7'd0, hi} + 13'd1);
		return (prod >> 1) + {7'd0, lo};
	endfunction

	state_t             state_q;
	logic               init_q;
	logic               clr_res_q;
	logic [MA_W-1:0]    sweep_q;
	logic [TC_W-1:0]    count_q;
	logic [TA_W-1:0]    i_q;
	logic [TA_W-1:0]    j_q;
	logic [TA_W-1:0]    idx_q;
	logic               ovf_q;
	logic               sat_q;
	logic [62:0]        sq_q;
	logic [31:0]        rows_q;
	logic               out_valid_q;

	snea_pkg::cmd_t     cmd_q;
	logic [5:0]         ci_q;
	logic [31:0]        ai_q;
	logic [MA_W-1:0]    k_q;
	logic               dup_q;
	tgt_t               tgt_q;
	logic [31:0]        opa_q;
	logic [31:0]        opb_q;
	logic [63:0]        p_q;
	logic               neg_q;
	logic [63:0]        mag_q;
	logic [63:0]        lo_q;
	logic [63:0]        hi_q;
	logic [63:0]        r_q;
	logic               rnd_q;
	logic               big_q;
	logic [63:0]        t_q;
	logic [63:0]        acc_q;
	logic [63:0]        res_data_q;
	logic [63:0]        out_data_q;
	logic [62:0]        out_sq_q;
	logic [31:0]        out_rows_q;
	logic               out_ovf_q;
	logic               out_sat_q;

	logic               ta_we;
	logic [TA_W-1:0]    ta_waddr;
	logic [TERM_W-1:0]  ta_wdata;
	logic [TA_W-1:0]    ta_raddr;
	logic [TERM_W-1:0]  ta_rdata;
	logic [TERM_W-1:0]  tb_rdata;
	logic               nm_we;
	logic [MA_W-1:0]    nm_waddr;
	logic [63:0]        nm_wdata;
	logic [MA_W-1:0]    nm_raddr;
	logic [63:0]        nm_rdata;
	logic               rh_we;
	logic [RHS_AW-1:0]  rh_waddr;
	logic [63:0]        rh_wdata;
	logic [RHS_AW-1:0]  rh_raddr;
	logic [63:0]        rh_rdata;

	logic signed [32:0] mult_a;
	logic signed [32:0] mult_b;
	logic signed [65:0] mult_p;
	logic signed [32:0] msum;
	logic               movf;
	logic [31:0]        mval;
	logic               match;
	logic [63:0]        t_val;
	logic               t_sat;
	logic [63:0]        acc_a;
	logic [63:0]        acc_sum;
	logic               acc_ovf;
	logic [63:0]        acc_res;
	logic [63:0]        sq_sum;
	logic               last_i;
	logic               last_j;
	logic               nm_step;
	logic               go_sq;
	logic               sat_set;
	logic               res_load;
	state_t             after_term;

	snea_ram #(.WIDTH(TERM_W), .DEPTH(MAX_TERMS)) u_terms_a (
		.clk(clk), .we(ta_we), .waddr(ta_waddr), .wdata(ta_wdata),
		.raddr(ta_raddr), .rdata(ta_rdata)
	);

	snea_ram #(.WIDTH(TERM_W), .DEPTH(MAX_TERMS)) u_terms_b (
		.clk(clk), .we(ta_we), .waddr(ta_waddr), .wdata(ta_wdata),
		.raddr(j_q), .rdata(tb_rdata)
	);

	snea_ram #(.WIDTH(64), .DEPTH(MAT_SIZE)) u_normal (
		.clk(clk), .we(nm_we), .waddr(nm_waddr), .wdata(nm_wdata),
		.raddr(nm_raddr), .rdata(nm_rdata)
	);

	snea_ram #(.WIDTH(64), .DEPTH(NUM_UNKNOWNS)) u_rhs (
		.clk(clk), .we(rh_we), .waddr(rh_waddr), .wdata(rh_wdata),
		.raddr(rh_raddr), .rdata(rh_rdata)
	);

	always_comb begin
		mult_a = {opa_q[31], opa_q};
		mult_b = {opb_q[31], opb_q};
		if (state_q == ST_MUL_L) begin
			mult_a = {1'b0, mag_q[31:0]};
			mult_b = {1'b0, cmd_q.obs_weight};
		end else if (state_q == ST_MUL_H) begin
			mult_a = {1'b0, mag_q[63:32]};
			mult_b = {1'b0, cmd_q.obs_weight};
		end
	end
	assign mult_p = mult_a * mult_b;

	assign match = ta_rdata[37:32] == cmd_q.column;
	assign msum  = {ta_rdata[31], ta_rdata[31:0]} + {cmd_q.coefficient[31], cmd_q.coefficient};
	assign movf  = msum[32] != msum[31];
	assign mval  = movf ? (msum[32] ? 32'h8000_0000 : 32'h7fff_ffff) : msum[31:0];

	always_comb begin
		t_sat = 1'b0;
		t_val = r_q;
		if (big_q) begin
			t_sat = 1'b1;
			t_val = neg_q ? S64_MIN : S64_MAX;
		end else if (!neg_q) begin
			if (r_q[63]) begin
				t_sat = 1'b1;
				t_val = S64_MAX;
			end
		end else if (r_q[63] && ((r_q[62:0] != 63'd0) || rnd_q)) begin
			t_sat = 1'b1;
			t_val = S64_MIN;
		end else if ((r_q == S64_MIN && !rnd_q) || (r_q == S64_MAX && rnd_q)) begin
			t_val = S64_MIN;
		end else begin
			t_val = rnd_q ? ~r_q : (~r_q + 64'd1);
		end
	end

	always_comb begin
		if (state_q == ST_ACC2) begin
			acc_a = acc_q;
		end else if (tgt_q == TGT_RHS) begin
			acc_a = rh_rdata;
		end else begin
			acc_a = nm_rdata;
		end
		acc_sum = acc_a + t_q;
		acc_ovf = (acc_a[63] == t_q[63]) && (acc_sum[63] != acc_a[63]);
		acc_res = acc_ovf ? (t_q[63] ? S64_MIN : S64_MAX) : acc_sum;
	end

	assign sq_sum = {1'b0, sq_q} + t_q;

	assign last_j   = j_q == i_q;
	assign last_i   = (TC_W'(i_q) + TC_W'(1)) == count_q;
	assign nm_step  = ((state_q == ST_ACC) && (tgt_q == TGT_NM) && !dup_q) || (state_q == ST_ACC2);
	assign go_sq    = ((state_q == ST_ROW_START) && (count_q == '0)) || (nm_step && last_j && last_i);
	assign res_load = (state_q == ST_RESULT) && (!out_valid_q || !result_stall);
	assign after_term = cmd_q.last_term ? ST_ROW_START : ST_IDLE;

	assign sat_set = ((state_q == ST_SRCH_CMP) && match && movf)
		| ((state_q == ST_SCALE2) && t_sat)
		| (((state_q == ST_ACC) && (tgt_q != TGT_SQ)) && acc_ovf)
		| ((state_q == ST_ACC2) && acc_ovf)
		| ((state_q == ST_ACC) && (tgt_q == TGT_SQ) && (sq_sum[63] || (&rows_q)));

	always_comb begin
		ta_we    = ((state_q == ST_SRCH_CMP) && match)
			|| ((state_q == ST_APPEND) && (count_q != TC_W'(MAX_TERMS)));
		ta_waddr = (state_q == ST_SRCH_CMP) ? idx_q : count_q[TA_W-1:0];
		ta_wdata = (state_q == ST_SRCH_CMP) ? {cmd_q.column, mval}
			: {cmd_q.column, cmd_q.coefficient};
		ta_raddr = (state_q == ST_SRCH_RD) ? idx_q : i_q;

		nm_we    = 1'b0;
		nm_waddr = k_q;
		nm_wdata = acc_res;
		rh_we    = 1'b0;
		rh_waddr = RHS_AW'(ci_q);
		rh_wdata = acc_res;
		if (state_q == ST_SWEEP) begin
			nm_we    = 1'b1;
			nm_waddr = sweep_q;
			nm_wdata = '0;
			rh_we    = sweep_q < MA_W'(NUM_UNKNOWNS);
			rh_waddr = RHS_AW'(sweep_q);
			rh_wdata = '0;
		end else if ((state_q == ST_ACC) && (tgt_q == TGT_RHS)) begin
			rh_we = 1'b1;
		end else if (((state_q == ST_ACC) && (tgt_q == TGT_NM)) || (state_q == ST_ACC2)) begin
			nm_we = 1'b1;
		end

		if (state_q == ST_RD_ADDR) begin
			nm_raddr = MA_W'(tri_index(cmd_q.column, cmd_q.read_column));
			rh_raddr = RHS_AW'(cmd_q.column);
		end else begin
			nm_raddr = k_q;
			rh_raddr = RHS_AW'(ci_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			init_q      <= 1'b1;
			clr_res_q   <= 1'b0;
			sweep_q     <= '0;
			count_q     <= '0;
			i_q         <= '0;
			j_q         <= '0;
			idx_q       <= '0;
			ovf_q       <= 1'b0;
			sat_q       <= 1'b0;
			sq_q        <= '0;
			rows_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= res_load | (out_valid_q & result_stall);
			if (sat_set) begin
				sat_q <= 1'b1;
			end
			unique case (state_q)
				ST_SWEEP: begin
					sweep_q <= sweep_q + MA_W'(1);
					if (sweep_q == MA_W'(MAT_SIZE - 1)) begin
						init_q  <= 1'b0;
						state_q <= clr_res_q ? ST_RESULT : ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (q_valid) begin
						unique case (q_cmd.op) inside
							snea_pkg::OP_CLEAR: begin
								count_q   <= '0;
								ovf_q     <= 1'b0;
								sat_q     <= 1'b0;
								sq_q      <= '0;
								rows_q    <= '0;
								sweep_q   <= '0;
								clr_res_q <= 1'b1;
								state_q   <= ST_SWEEP;
							end
							snea_pkg::OP_READ_N, snea_pkg::OP_READ_B: begin
								state_q <= ST_RD_ADDR;
							end
							snea_pkg::OP_TERM: begin
								if (count_q == '0) begin
									ovf_q <= 1'b0;
								end
								if (!q_cmd.column_ok) begin
									state_q <= q_cmd.last_term ? ST_ROW_START : ST_IDLE;
								end else if (merge_duplicates && (count_q != '0)) begin
									idx_q   <= '0;
									state_q <= ST_SRCH_RD;
								end else begin
									state_q <= ST_APPEND;
								end
							end
						endcase
					end
				end
				ST_SRCH_RD: begin
					state_q <= ST_SRCH_CMP;
				end
				ST_SRCH_CMP: begin
					if (match) begin
						state_q <= after_term;
					end else if ((TC_W'(idx_q) + TC_W'(1)) == count_q) begin
						state_q <= ST_APPEND;
					end else begin
						idx_q   <= idx_q + TA_W'(1);
						state_q <= ST_SRCH_RD;
					end
				end
				ST_APPEND: begin
					if (count_q == TC_W'(MAX_TERMS)) begin
						ovf_q <= 1'b1;
					end else begin
						count_q <= count_q + TC_W'(1);
					end
					state_q <= after_term;
				end
				ST_RD_ADDR: begin
					state_q <= ST_RD_DATA;
				end
				ST_RD_DATA: begin
					state_q <= ST_RESULT;
				end
				ST_ROW_START: begin
					if (count_q == '0) begin
						state_q <= ST_MUL_P;
					end else begin
						i_q     <= '0;
						state_q <= ST_ROW_RD_I;
					end
				end
				ST_ROW_RD_I: begin
					state_q <= ST_ROW_GET_I;
				end
				ST_ROW_GET_I: begin
					state_q <= ST_MUL_P;
				end
				ST_ROW_RD_J: begin
					state_q <= ST_ROW_GET_J;
				end
				ST_ROW_GET_J: begin
					state_q <= ST_MUL_P;
				end
				ST_MUL_P: begin
					state_q <= ST_ABS;
				end
				ST_ABS: begin
					state_q <= ST_MUL_L;
				end
				ST_MUL_L: begin
					state_q <= ST_MUL_H;
				end
				ST_MUL_H: begin
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					state_q <= ST_SCALE2;
				end
				ST_SCALE2: begin
					state_q <= ST_ACC;
				end
				ST_ACC, ST_ACC2: begin
					if ((state_q == ST_ACC) && (tgt_q == TGT_RHS)) begin
						j_q     <= '0;
						state_q <= ST_ROW_RD_J;
					end else if ((state_q == ST_ACC) && (tgt_q == TGT_SQ)) begin
						if (sq_sum[63]) begin
							sq_q <= S64_MAX[62:0];
						end else begin
							sq_q <= sq_sum[62:0];
						end
						if (!(&rows_q)) begin
							rows_q <= rows_q + 32'd1;
						end
						count_q <= '0;
						state_q <= ST_RESULT;
					end else if ((state_q == ST_ACC) && dup_q) begin
						state_q <= ST_ACC2;
					end else if (last_j) begin
						if (last_i) begin
							state_q <= ST_MUL_P;
						end else begin
							i_q     <= i_q + TA_W'(1);
							state_q <= ST_ROW_RD_I;
						end
					end else begin
						j_q     <= j_q + TA_W'(1);
						state_q <= ST_ROW_RD_J;
					end
				end
				ST_RESULT: begin
					if (res_load) begin
						clr_res_q <= 1'b0;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					cmd_q      <= q_cmd;
					res_data_q <= '0;
				end
			end
			ST_RD_DATA: begin
				if (cmd_q.op == snea_pkg::OP_READ_N) begin
					res_data_q <= (cmd_q.column_ok && cmd_q.read_column_ok) ? nm_rdata : '0;
				end else begin
					res_data_q <= cmd_q.column_ok ? rh_rdata : '0;
				end
			end
			ST_ROW_GET_I: begin
				ci_q  <= ta_rdata[37:32];
				ai_q  <= ta_rdata[31:0];
				opa_q <= ta_rdata[31:0];
				opb_q <= cmd_q.obs_value;
				tgt_q <= TGT_RHS;
			end
			ST_ROW_GET_J: begin
				opa_q <= ai_q;
				opb_q <= tb_rdata[31:0];
				k_q   <= MA_W'(tri_index(ci_q, tb_rdata[37:32]));
				dup_q <= (j_q != i_q) && (tb_rdata[37:32] == ci_q);
				tgt_q <= TGT_NM;
			end
			ST_MUL_P: begin
				p_q <= mult_p[63:0];
			end
			ST_ABS: begin
				neg_q <= p_q[63];
				mag_q <= p_q[63] ? (~p_q + 64'd1) : p_q;
			end
			ST_MUL_L: begin
				lo_q <= mult_p[63:0];
			end
			ST_MUL_H: begin
				hi_q <= mult_p[63:0];
			end
			ST_SCALE: begin
				big_q <= hi_q[63:47] != 17'd0;
				r_q   <= {hi_q[47:0], 16'd0} + {16'd0, lo_q[63:16]};
				rnd_q <= lo_q[15:0] != 16'd0;
			end
			ST_SCALE2: begin
				t_q <= t_val;
			end
			ST_ACC: begin
				acc_q <= acc_res;
			end
			ST_RESULT: begin
				if (res_load) begin
					out_data_q <= res_data_q;
					out_sq_q   <= sq_q;
					out_rows_q <= rows_q;
					out_ovf_q  <= ovf_q;
					out_sat_q  <= sat_q;
				end
			end
			default: begin
			end
		endcase
		if (go_sq) begin
			opa_q <= cmd_q.obs_value;
			opb_q <= cmd_q.obs_value;
			tgt_q <= TGT_SQ;
		end
	end

	assign status.pop         = (state_q == ST_IDLE) && q_valid;
	assign status.init        = init_q;
	assign result_valid       = out_valid_q;
	assign read_data          = out_data_q;
	assign residual_sum       = out_sq_q;
	assign observation_count  = out_rows_q;
	assign row_overflow       = out_ovf_q;
	assign saturated          = out_sat_q;

endmodule

>>> hw/rtl/sparse_normal_equation_accumulator.sv
// Sparse least-squares normal-equation accumulator. Term beats of a row are queued and
// collected (merged by column when merge_duplicates is set); the last term sums the row
// into the lower triangle of N, into b, the weighted square sum and the row count, all
// saturating (the sums in Q32.32), and returns one result beat, as do reads of N or b
// and clear. A two-entry queue lets input beats be taken while the sequencer works. One
// shared 33x33 multiplier runs three products per multiply-accumulate; an n-term row
// makes (n+1)(n+2)/2 accumulations, with one more for each repeated column pair. When
// merging, a term beat searches the held terms for its column. After reset and on every
// clear, a pass over all matrix entries zeroes the matrix and vector memories; no input
// beat is taken during the pass after reset.
module sparse_normal_equation_accumulator #(
	parameter int NUM_UNKNOWNS = 64,
	parameter int MAX_TERMS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [1:0]         kind,
	input  logic [5:0]         column,
	input  logic [5:0]         read_column,
	input  logic signed [31:0] coefficient,
	input  logic signed [31:0] obs_value,
	input  logic [31:0]        obs_weight,
	input  logic               last_term,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [63:0] read_data,
	output logic [62:0]        residual_sum,
	output logic [31:0]        observation_count,
	output logic               row_overflow,
	output logic               saturated
);

	logic              merge_q;
	logic              q_valid;
	snea_pkg::cmd_t    q_cmd;
	snea_pkg::status_t back_status;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == snea_pkg::REG_MERGE_DUPLICATES) ? {31'd0, merge_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			merge_q <= 1'b1;
		end else if (psel && penable && pwrite && pready
			&& (paddr[2] == snea_pkg::REG_MERGE_DUPLICATES)) begin
			merge_q <= pwdata[0];
		end
	end

	snea_front #(.NUM_UNKNOWNS(NUM_UNKNOWNS)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.kind(kind),
		.column(column),
		.read_column(read_column),
		.coefficient(coefficient),
		.obs_value(obs_value),
		.obs_weight(obs_weight),
		.last_term(last_term),
		.back_status(back_status),
		.q_valid(q_valid),
		.q_cmd(q_cmd)
	);

	snea_back #(.NUM_UNKNOWNS(NUM_UNKNOWNS), .MAX_TERMS(MAX_TERMS)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.merge_duplicates(merge_q),
		.q_valid(q_valid),
		.q_cmd(q_cmd),
		.status(back_status),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.read_data(read_data),
		.residual_sum(residual_sum),
		.observation_count(observation_count),
		.row_overflow(row_overflow),
		.saturated(saturated)
	);

endmodule

>>> bench/accumulator_checker.sv
module accumulator_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  logic               item_stall,
	input  logic [1:0]         kind,
	input  logic [5:0]         column,
	input  logic [5:0]         read_column,
	input  logic signed [31:0] coefficient,
	input  logic signed [31:0] obs_value,
	input  logic [31:0]        obs_weight,
	input  logic               last_term,
	input  logic               result_valid,
	input  logic               result_stall,
	input  logic signed [63:0] read_data,
	input  logic [62:0]        residual_sum,
	input  logic [31:0]        observation_count,
	input  logic               row_overflow,
	input  logic               saturated,
	input  logic               merge_setting,
	output int                 error_count,
	output int                 pending
);

	localparam int NU = 64;
	localparam int MT = 16;
	localparam longint SMAX = 64'sh7FFFFFFFFFFFFFFF;
	localparam longint SMIN = 64'sh8000000000000000;

	typedef struct packed {
		logic signed [63:0] data;
		logic [62:0]        ssum;
		logic [31:0]        count;
		logic               ovf;
		logic               sat;
	} summary_t;

	summary_t expected_q[$];
	logic [5:0]         row_cols[MT];
	logic signed [31:0] row_coefs[MT];
	int                 held;
	longint             nmat[NU*(NU+1)/2];
	longint             rhs[NU];
	logic [63:0]        sq_sum;
	logic [31:0]        rows;
	logic               ovf_flag, sat_flag;

	assign pending = expected_q.size();

	function automatic int tri_pos(int r, int c);
		int t;
		if (r < c) begin
			t = r; r = c; c = t;
		end
		return r * (r + 1) / 2 + c;
	endfunction

	function automatic longint weigh(longint p, logic [31:0] w);
		logic [63:0] mag, lo, hi, r, c;
		mag = p < 0 ? -p : p;
		lo = {32'b0, mag[31:0]} * {32'b0, w};
		hi = {32'b0, mag[63:32]} * {32'b0, w};
		if (hi >= 64'd1 << 47) begin
			sat_flag = 1;
			return p < 0 ? SMIN : SMAX;
		end
		r = (hi << 16) + (lo >> 16);
		if (p >= 0) begin
			if (r > 64'h7FFFFFFFFFFFFFFF) begin
				sat_flag = 1;
				return SMAX;
			end
			return r;
		end
		c = r + (lo[15:0] != 0);
		if (c > 64'h8000000000000000) begin
			sat_flag = 1;
			return SMIN;
		end
		if (c == 64'h8000000000000000) return SMIN;
		return -c;
	endfunction

	function automatic longint acc(longint a, longint b);
		longint s;
		s = a + b;
		if (b > 0 && s < a) begin
			sat_flag = 1;
			return SMAX;
		end
		if (b < 0 && s > a) begin
			sat_flag = 1;
			return SMIN;
		end
		return s;
	endfunction

	task automatic wipe();
		foreach (nmat[k]) nmat[k] = 0;
		foreach (rhs[k]) rhs[k] = 0;
		held = 0;
		sq_sum = 0;
		rows = 0;
		ovf_flag = 0;
		sat_flag = 0;
	endtask

	task automatic collect(int col, longint coef);
		longint s;
		if (held == 0) ovf_flag = 0;
		if (merge_setting) begin
			for (int i = 0; i < held; i++) begin
				if (row_cols[i] == col) begin
					s = row_coefs[i] + coef;
					if (s > 64'sh7FFFFFFF) begin
						s = 64'sh7FFFFFFF; sat_flag = 1;
					end
					if (s < -64'sh80000000) begin
						s = -64'sh80000000; sat_flag = 1;
					end
					row_coefs[i] = 32'(s);
					return;
				end
			end
		end
		if (held >= MT) begin
			ovf_flag = 1;
			return;
		end
		row_cols[held] = 6'(col);
		row_coefs[held] = 32'(coef);
		held++;
	endtask

	task automatic fold_row(longint v, logic [31:0] w);
		longint ai, t;
		int ci, cj, k;
		logic [63:0] s;
		for (int i = 0; i < held; i++) begin
			ci = row_cols[i];
			ai = row_coefs[i];
			rhs[ci] = acc(rhs[ci], weigh(ai * v, w));
			for (int j = 0; j <= i; j++) begin
				cj = row_cols[j];
				k = tri_pos(ci, cj);
				t = weigh(ai * longint'(row_coefs[j]), w);
				nmat[k] = acc(nmat[k], t);
				if (j < i && cj == ci) nmat[k] = acc(nmat[k], t);
			end
		end
		s = weigh(v * v, w);
		if (s > 64'h7FFFFFFFFFFFFFFF - sq_sum) begin
			sq_sum = 64'h7FFFFFFFFFFFFFFF; sat_flag = 1;
		end else sq_sum += s;
		if (rows == 32'hFFFFFFFF) sat_flag = 1;
		else rows++;
		held = 0;
	endtask

	task automatic predict_beat();
		summary_t e;
		longint d;
		d = 0;
		case (kind)
			snea_pkg::KIND_TERM: begin
				collect(column, coefficient);
				if (!last_term) return;
				fold_row(obs_value, obs_weight);
			end
			snea_pkg::KIND_READ_N: d = nmat[tri_pos(column, read_column)];
			snea_pkg::KIND_READ_B: d = rhs[column];
			default: wipe();
		endcase
		e.data = d;
		e.ssum = sq_sum[62:0];
		e.count = rows;
		e.ovf = ovf_flag;
		e.sat = sat_flag;
		expected_q.push_back(e);
	endtask

	task automatic compare_beat();
		summary_t e;
		if (expected_q.size() == 0) begin
			$error("result beat with nothing expected");
			error_count++;
			return;
		end
		e = expected_q.pop_front();
		if (read_data !== e.data) begin
			$error("read_data expected %0d got %0d", e.data, read_data); error_count++;
		end
		if (residual_sum !== e.ssum) begin
			$error("residual_sum expected %0d got %0d", e.ssum, residual_sum); error_count++;
		end
		if (observation_count !== e.count) begin
			$error("observation_count expected %0d got %0d", e.count, observation_count);
			error_count++;
		end
		if (row_overflow !== e.ovf) begin
			$error("row_overflow expected %0d got %0d", e.ovf, row_overflow); error_count++;
		end
		if (saturated !== e.sat) begin
			$error("saturated expected %0d got %0d", e.sat, saturated); error_count++;
		end
	endtask

	initial begin
		error_count = 0;
		wipe();
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) compare_beat();
			if (item_valid && !item_stall) predict_beat();
		end
	end
endmodule

>>> bench/testbench.sv
module testbench;

	logic               clk, arst_n;
	logic               psel, penable, pwrite;
	logic [2:0]         paddr;
	logic [31:0]        pwdata, prdata;
	logic               pready;
	logic               item_valid, item_stall;
	logic [1:0]         kind;
	logic [5:0]         column, read_column;
	logic signed [31:0] coefficient, obs_value;
	logic [31:0]        obs_weight;
	logic               last_term;
	logic               result_valid, result_stall;
	logic signed [63:0] read_data;
	logic [62:0]        residual_sum;
	logic [31:0]        observation_count;
	logic               row_overflow, saturated;
	logic               merge_setting;
	int                 error_count, pending;
	longint             cycles;
	int                 sent;

	sparse_normal_equation_accumulator uut (.*);

	accumulator_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 3000000) begin
				$display("testbench: errors");
				$finish;
			end
		end
	end

	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
		if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
		return 0;
	endfunction

	initial begin
		result_stall = 0;
		forever begin
			@(negedge clk);
			if (cycles % 3000 < 600) result_stall <= 0;
			else result_stall <= ($urandom_range(0, 19) == 0) ? 1 : ($urandom_range(0, 3) == 0);
		end
	end

	task automatic send(logic [1:0] k, logic [5:0] c, logic [5:0] rc, logic [31:0] cf,
			logic [31:0] v, logic [31:0] w, logic lt);
		int g;
		g = (cycles % 3000 < 600) ? 0 : gap_len();
		if (g > 0) begin
			item_valid <= 0;
			repeat (g) @(negedge clk);
		end
		item_valid <= 1;
		kind <= k; column <= c; read_column <= rc;
		coefficient <= cf; obs_value <= v; obs_weight <= w; last_term <= lt;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	task automatic write_merge(logic val);
		item_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (2000) @(negedge clk);
		psel <= 1; pwrite <= 1; paddr <= 3'd0; pwdata <= {$urandom_range(0, 1) ? 31'h7FFFFFFF : 31'h0, val};
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		merge_setting = val;
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return 32'hFFFFFFFF;
			3: return $urandom_range(0, 3) << 16;
			default: return $urandom;
		endcase
	endfunction

	task automatic random_row();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 20) : $urandom_range(0, 5);
		for (int i = 0; i < n; i++)
			send(snea_pkg::KIND_TERM, 6'($urandom_range(0, 7)), 6'($urandom), rand_word(),
				$urandom, $urandom, 1'b0);
		send(snea_pkg::KIND_TERM, 6'($urandom_range(0, 7)), 6'($urandom), rand_word(),
			rand_word(), $urandom_range(0, 1) ? rand_word() : 32'h10000, 1'b1);
		send(snea_pkg::KIND_READ_N, 6'($urandom_range(0, 7)), 6'($urandom_range(0, 7)),
			$urandom, $urandom, $urandom, 1'($urandom));
		send(snea_pkg::KIND_READ_B, 6'($urandom_range(0, 7)), 6'($urandom), $urandom,
			$urandom, $urandom, 1'($urandom));
	endtask

	initial begin
		sent = 0;
		merge_setting = 1;
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		item_valid = 0; kind = 0; column = 0; read_column = 0;
		coefficient = 0; obs_value = 0; obs_weight = 0; last_term = 0;
		repeat (4) @(negedge clk);
		arst_n = 1;
		send(snea_pkg::KIND_TERM, 6'd0, 6'd0, 32'h10000, 32'd0, 32'd0, 1'b0);
		send(snea_pkg::KIND_TERM, 6'd0, 6'd0, 32'h7FFFFFFF, 32'd0, 32'd0, 1'b0);
		send(snea_pkg::KIND_TERM, 6'd63, 6'd0, 32'h80000000, 32'd0, 32'd0, 1'b0);
		send(snea_pkg::KIND_TERM, 6'd5, 6'd0, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 1'b1);
		send(snea_pkg::KIND_READ_N, 6'd0, 6'd0, 32'd0, 32'd0, 32'd0, 1'b1);
		send(snea_pkg::KIND_READ_N, 6'd5, 6'd63, 32'd0, 32'd0, 32'd0, 1'b0);
		send(snea_pkg::KIND_READ_N, 6'd0, 6'd5, 32'd0, 32'd0, 32'd0, 1'b0);
		send(snea_pkg::KIND_READ_B, 6'd63, 6'd0, 32'd0, 32'd0, 32'd0, 1'b0);
		send(snea_pkg::KIND_TERM, 6'd1, 6'd0, 32'd0, 32'h80000000, 32'h10000, 1'b1);
		send(snea_pkg::KIND_TERM, 6'd9, 6'd0, 32'd0, 32'h80000000, 32'd0, 1'b1);
		for (int i = 0; i < 18; i++)
			send(snea_pkg::KIND_TERM, 6'(i), 6'd0, 32'h20000, 32'd0, 32'd0, i == 17);
		send(snea_pkg::KIND_CLEAR, 6'd0, 6'd0, 32'd0, 32'd0, 32'd0, 1'b1);
		write_merge(0);
		send(snea_pkg::KIND_TERM, 6'd3, 6'd0, 32'h10000, 32'd0, 32'd0, 1'b0);
		send(snea_pkg::KIND_TERM, 6'd3, 6'd0, 32'h10000, 32'h10000, 32'h10000, 1'b1);
		send(snea_pkg::KIND_READ_N, 6'd3, 6'd3, 32'd0, 32'd0, 32'd0, 1'b0);
		for (int ph = 0; ph < 4; ph++) begin
			write_merge(ph[0]);
			while (sent < 400 * (ph + 1)) begin
				if ($urandom_range(0, 60) == 0)
					send(snea_pkg::KIND_CLEAR, 6'($urandom), 6'($urandom), $urandom,
						$urandom, $urandom, 1'($urandom));
				else random_row();
			end
		end
		item_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (3000) @(negedge clk);
		if (error_count == 0 && pending == 0) $display("testbench: clean");
		else $display("testbench: errors");
		$finish;
	end
endmodule

>>> sim.f
hw/rtl/snea_pkg.sv
hw/rtl/snea_ram.sv
hw/rtl/snea_front.sv
hw/rtl/snea_back.sv
hw/rtl/sparse_normal_equation_accumulator.sv
bench/accumulator_checker.sv
bench/testbench.sv
